### rtl/core/bbcm_pkg.sv
package bbcm_pkg;

  localparam int unsigned SlotLimit = 32;
  localparam logic [7:0] CountMax = 8'hFF;

  typedef enum logic [1:0] {
    KindGet     = 2'd0,
    KindRelease = 2'd1,
    KindPin     = 2'd2,
    KindUnpin   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusNoFree   = 2'd1,
    StatusNotInUse = 2'd2,
    StatusCount    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StApply
  } ctrl_state_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  device_number;
    logic [31:0] block_number;
    logic [4:0]  slot;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [4:0] granted_slot;
    logic       was_hit;
    logic       read_needed;
    logic       entry_freed;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/core/block_buffer_cache_manager.sv
// Reference-counted block buffer cache with min(BUFFER_COUNT, 32) entries, tagged by
// device and block number. A get scans the tag memory one entry per cycle, stopping at
// the first in-use match and noting the lowest free entry, then moves to the apply step;
// release, pin and unpin go straight from idle to the apply step, which waits for a free
// output register. One word is worked on at a time, and a new word is taken while
// the previous result waits in the output register.
module block_buffer_cache_manager import bbcm_pkg::*; #(
  parameter int unsigned BUFFER_COUNT = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bbcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_req_i.kind),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bbcm_dp #(
    .BUFFER_COUNT (BUFFER_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

### rtl/core/bbcm_ctrl.sv
module bbcm_ctrl import bbcm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  kind_e    in_kind_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_kind_i == KindGet) ? StScan : StApply;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = StApply;
        end
      end
      StApply: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

### rtl/core/bbcm_dp.sv
module bbcm_dp import bbcm_pkg::*; #(
  parameter int unsigned BUFFER_COUNT = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  req_t     in_req_i,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rsp_t     out_rsp_o
);

  localparam int unsigned Usable = (BUFFER_COUNT < SlotLimit) ? BUFFER_COUNT : SlotLimit;
  localparam int unsigned IdxW   = $clog2(Usable);
  localparam int unsigned CtrW   = $clog2(Usable + 1);
  localparam int unsigned TagW   = 40;

  req_t              req_q;
  logic [TagW-1:0]   tag_mem [Usable];
  logic [TagW-1:0]   tag_rd_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic              rd_vld_q;
  logic [CtrW-1:0]   ctr_q;
  logic              hit_fnd_q, free_fnd_q;
  logic [IdxW-1:0]   hit_idx_q, free_idx_q;
  logic [Usable-1:0] in_use_q, valid_q;
  logic [7:0]        count_q [Usable];
  logic              out_valid_q;
  rsp_t              out_rsp_q;

  logic            issue, ev, match_now, free_now;
  logic [TagW-1:0] req_tag;
  logic [IdxW-1:0] e_idx;
  logic            slot_ok;
  logic [7:0]      cnt;
  rsp_t            rsp;
  logic            wr_cnt, wr_alloc, wr_valid, wr_free;
  logic [7:0]      cnt_new;

  assign req_tag   = {req_q.device_number, req_q.block_number};
  assign ev        = rd_vld_q && !hit_fnd_q;
  assign match_now = ev && in_use_q[rd_idx_q] && (tag_rd_q == req_tag);
  assign free_now  = ev && !in_use_q[rd_idx_q] && !free_fnd_q;
  assign issue     = cmd_i.scan && !hit_fnd_q && !match_now && (ctr_q != CtrW'(Usable));

  assign stat_o.scan_done = hit_fnd_q || ((ctr_q == CtrW'(Usable)) && !rd_vld_q);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_req_i;
    end
    if (issue) begin
      tag_rd_q <= tag_mem[ctr_q[IdxW-1:0]];
      rd_idx_q <= ctr_q[IdxW-1:0];
    end
    if (wr_alloc) begin
      tag_mem[e_idx] <= req_tag;
    end
    if (match_now) begin
      hit_idx_q <= rd_idx_q;
    end
    if (free_now) begin
      free_idx_q <= rd_idx_q;
    end
    if (cmd_i.commit) begin
      out_rsp_q <= rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q      <= '0;
      rd_vld_q   <= 1'b0;
      hit_fnd_q  <= 1'b0;
      free_fnd_q <= 1'b0;
    end else if (cmd_i.load) begin
      ctr_q      <= '0;
      rd_vld_q   <= 1'b0;
      hit_fnd_q  <= 1'b0;
      free_fnd_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (issue) begin
        ctr_q <= ctr_q + 1'b1;
      end
      if (match_now) begin
        hit_fnd_q <= 1'b1;
      end
      if (free_now) begin
        free_fnd_q <= 1'b1;
      end
    end
  end

  assign slot_ok = ({1'b0, req_q.slot} < 6'(Usable));
  assign e_idx   = (req_q.kind != KindGet) ? req_q.slot[IdxW-1:0] :
                   (hit_fnd_q ? hit_idx_q : free_idx_q);
  assign cnt     = count_q[e_idx];

  always_comb begin
    rsp              = '0;
    rsp.status       = StatusOk;
    rsp.granted_slot = req_q.slot;
    wr_cnt           = 1'b0;
    wr_alloc         = 1'b0;
    wr_valid         = 1'b0;
    wr_free          = 1'b0;
    cnt_new          = cnt;
    if (req_q.kind == KindGet) begin
      if (hit_fnd_q) begin
        rsp.granted_slot = 5'(e_idx);
        rsp.was_hit      = 1'b1;
        if (cnt == CountMax) begin
          rsp.status = StatusCount;
        end else begin
          wr_cnt           = 1'b1;
          cnt_new          = cnt + 8'd1;
          rsp.read_needed  = !valid_q[e_idx];
          wr_valid         = !valid_q[e_idx];
        end
      end else if (free_fnd_q) begin
        rsp.granted_slot = 5'(e_idx);
        wr_alloc         = 1'b1;
        wr_cnt           = 1'b1;
        cnt_new          = 8'd1;
        rsp.read_needed  = 1'b1;
        wr_valid         = 1'b1;
      end else begin
        rsp.status       = StatusNoFree;
        rsp.granted_slot = '0;
      end
    end else if (!slot_ok || !in_use_q[e_idx]) begin
      rsp.status = StatusNotInUse;
    end else if (req_q.kind == KindPin) begin
      if (cnt == CountMax) begin
        rsp.status = StatusCount;
      end else begin
        wr_cnt  = 1'b1;
        cnt_new = cnt + 8'd1;
      end
    end else if (cnt == 8'd0) begin
      rsp.status = StatusCount;
    end else begin
      wr_cnt  = 1'b1;
      cnt_new = cnt - 8'd1;
      if (req_q.kind == KindRelease && cnt == 8'd1) begin
        wr_free         = 1'b1;
        rsp.entry_freed = 1'b1;
      end
    end
    wr_cnt   = wr_cnt && cmd_i.commit;
    wr_alloc = wr_alloc && cmd_i.commit;
    wr_valid = wr_valid && cmd_i.commit;
    wr_free  = wr_free && cmd_i.commit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q    <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < Usable; i++) begin
        count_q[i] <= '0;
      end
    end else begin
      if (wr_cnt) begin
        count_q[e_idx] <= cnt_new;
      end
      if (wr_alloc) begin
        in_use_q[e_idx] <= 1'b1;
      end
      if (wr_free) begin
        in_use_q[e_idx] <= 1'b0;
      end
      if (wr_valid) begin
        valid_q[e_idx] <= 1'b1;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
